### rtl/core/ttfd_pkg.sv
// Shared types and constants for the trainer telemetry frame decoder.
// No dependencies; used by every module of the block.
package ttfd_pkg;

    localparam int SCAN_DEPTH_DEF = 24;
    localparam int FRAME_LEN      = 7;
    localparam int SAMPLE_W       = 7;
    localparam int SNAP_IDX_W     = 5;
    localparam int ROT_OFFSET     = 3;

    localparam logic RESULT_FRAME = 1'b0;
    localparam logic RESULT_SNAP  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FRAME,
        ST_SNAP,
        ST_WRITE
    } state_t;

    typedef enum logic [1:0] {
        SEL_SCAN_A,
        SEL_SCAN_B,
        SEL_SCAN_C
    } scan_sel_t;

    typedef struct packed {
        logic [3:0] msg_type;
        logic [7:0] value_short;
        logic [11:0] value_long;
        logic [8:0] button_bits;
        logic [7:0] scan_a;
        logic [7:0] scan_b;
        logic [7:0] scan_c;
    } frame_t;

    typedef struct packed {
        logic                  result_kind;
        frame_t                fields;
        logic [SNAP_IDX_W-1:0] snap_index;
        logic [SAMPLE_W-1:0]   snap_value;
        logic                  last;
    } result_t;

endpackage

### rtl/core/trainer_telemetry_frame_decoder.sv
// Top level of the trainer telemetry frame decoder: byte gatherer, sequencer
// and spin-scan store. Depends on ttfd_pkg, ttfd_gather, ttfd_ctrl, ttfd_scan_mem.
//
//   channel   ports                             transfer when
//   input     s_valid s_ready s_rx_byte         s_valid && s_ready
//   result    m_valid m_ready m_result_kind..   m_valid && m_ready
//             m_last
//
// A new byte is taken only in idle. A synced frame then gives the frame
// result, then a snapshot when requested (one store read per entry), then up
// to three sample writes through the single store write port when a scan is
// nonzero. Reset (aresetn low, synchronous) clears the sequencer and store
// valid bits. A held result with m_ready low stalls frame and snapshot output.
module trainer_telemetry_frame_decoder #(
    parameter int SCAN_DEPTH = ttfd_pkg::SCAN_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_result_kind,
    output logic [3:0]  m_msg_type,
    output logic [7:0]  m_value_short,
    output logic [11:0] m_value_long,
    output logic [8:0]  m_button_bits,
    output logic [7:0]  m_scan_a,
    output logic [7:0]  m_scan_b,
    output logic [7:0]  m_scan_c,
    output logic [4:0]  m_snap_index,
    output logic [6:0]  m_snap_value,
    output logic        m_last
);

    localparam int IDX_W = $clog2(SCAN_DEPTH);

    logic                          byte_accept;
    logic                          frame_sync;
    ttfd_pkg::frame_t              frame;
    ttfd_pkg::result_t             result;
    logic                          wr_en;
    logic [IDX_W-1:0]              wr_addr;
    logic [ttfd_pkg::SAMPLE_W-1:0] wr_data;
    logic                          rd_en;
    logic [IDX_W-1:0]              rd_addr;
    logic [ttfd_pkg::SAMPLE_W-1:0] rd_data;

    assign byte_accept = s_valid && s_ready;

    ttfd_gather u_gather (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .byte_accept (byte_accept),
        .rx_byte     (s_rx_byte),
        .frame_sync  (frame_sync),
        .frame       (frame)
    );

    ttfd_scan_mem #(
        .SCAN_DEPTH (SCAN_DEPTH)
    ) u_scan_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    ttfd_ctrl #(
        .SCAN_DEPTH (SCAN_DEPTH)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_ready    (s_ready),
        .frame_sync (frame_sync),
        .frame      (frame),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data),
        .result     (result),
        .m_valid    (m_valid),
        .m_ready    (m_ready)
    );

    assign m_result_kind = result.result_kind;
    assign m_msg_type    = result.fields.msg_type;
    assign m_value_short = result.fields.value_short;
    assign m_value_long  = result.fields.value_long;
    assign m_button_bits = result.fields.button_bits;
    assign m_scan_a      = result.fields.scan_a;
    assign m_scan_b      = result.fields.scan_b;
    assign m_scan_c      = result.fields.scan_c;
    assign m_snap_index  = result.snap_index;
    assign m_snap_value  = result.snap_value;
    assign m_last        = result.last;

endmodule

### rtl/core/ttfd_gather.sv
// Byte gathering into 7-byte frames with sync check on the seventh byte,
// and unpacking of the held frame into its fields. Depends on ttfd_pkg.
module ttfd_gather (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              byte_accept,
    input  logic [7:0]        rx_byte,
    output logic              frame_sync,
    output ttfd_pkg::frame_t  frame
);

    localparam logic [2:0] LAST_SLOT = 3'(ttfd_pkg::FRAME_LEN - 1);

    logic [7:0] frame_bytes_reg [ttfd_pkg::FRAME_LEN];
    logic [2:0] byte_count_reg;
    logic [2:0] byte_count_next;
    logic [7:0] raw_a;
    logic [7:0] raw_b;
    logic [7:0] raw_c;
    logic [7:0] tail;

    assign frame_sync = byte_accept && (byte_count_reg == LAST_SLOT) && rx_byte[7];

    always_comb begin
        byte_count_next = byte_count_reg;
        if (byte_accept) begin
            if (byte_count_reg != LAST_SLOT) begin
                byte_count_next = byte_count_reg + 3'd1;
            end else if (rx_byte[7]) begin
                byte_count_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_count_reg <= '0;
        end else begin
            byte_count_reg <= byte_count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (byte_accept) begin
            frame_bytes_reg[byte_count_reg] <= rx_byte;
        end
    end

    assign tail  = frame_bytes_reg[6];
    assign raw_a = {frame_bytes_reg[0][6:0], tail[5]};
    assign raw_b = {frame_bytes_reg[1][6:0], tail[4]};
    assign raw_c = {frame_bytes_reg[2][6:0], tail[3]};

    always_comb begin
        frame.scan_a      = {raw_a[3:0], raw_a[7:4]};
        frame.scan_b      = {raw_b[3:0], raw_b[7:4]};
        frame.scan_c      = {raw_c[3:0], raw_c[7:4]};
        frame.button_bits = {frame_bytes_reg[3], tail[2]};
        frame.msg_type    = frame_bytes_reg[4][6:3];
        frame.value_short = {frame_bytes_reg[5][6:0], tail[0]};
        frame.value_long  = {frame_bytes_reg[4][2:0], tail[1], frame_bytes_reg[5][6:0], tail[0]};
    end

endmodule

### rtl/core/ttfd_scan_mem.sv
// Spin-scan sample store: one write port, one registered read port,
// per-entry valid bits so unwritten entries read as zero. Depends on ttfd_pkg.
module ttfd_scan_mem #(
    parameter int  SCAN_DEPTH = ttfd_pkg::SCAN_DEPTH_DEF,
    localparam int IDX_W      = $clog2(SCAN_DEPTH)
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          wr_en,
    input  logic [IDX_W-1:0]              wr_addr,
    input  logic [ttfd_pkg::SAMPLE_W-1:0] wr_data,
    input  logic                          rd_en,
    input  logic [IDX_W-1:0]              rd_addr,
    output logic [ttfd_pkg::SAMPLE_W-1:0] rd_data
);

    logic [ttfd_pkg::SAMPLE_W-1:0] mem [SCAN_DEPTH];
    logic [SCAN_DEPTH-1:0]         valid_reg;
    logic [ttfd_pkg::SAMPLE_W-1:0] rd_q_reg;
    logic                          rd_vld_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (wr_en) begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_q_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_vld_reg <= 1'b0;
        end else if (rd_en) begin
            rd_vld_reg <= valid_reg[rd_addr];
        end
    end

    assign rd_data = rd_vld_reg ? rd_q_reg : '0;

endmodule

### rtl/core/ttfd_ctrl.sv
// Sequencer: emits the frame result, walks the rotated snapshot readout and
// writes up to three inverted samples through one store port. Depends on ttfd_pkg.
module ttfd_ctrl #(
    parameter int  SCAN_DEPTH = ttfd_pkg::SCAN_DEPTH_DEF,
    localparam int IDX_W      = $clog2(SCAN_DEPTH),
    localparam int POS_W      = $clog2(SCAN_DEPTH + 1)
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    output logic                          s_ready,
    input  logic                          frame_sync,
    input  ttfd_pkg::frame_t              frame,
    output logic                          wr_en,
    output logic [IDX_W-1:0]              wr_addr,
    output logic [ttfd_pkg::SAMPLE_W-1:0] wr_data,
    output logic                          rd_en,
    output logic [IDX_W-1:0]              rd_addr,
    input  logic [ttfd_pkg::SAMPLE_W-1:0] rd_data,
    output ttfd_pkg::result_t             result,
    output logic                          m_valid,
    input  logic                          m_ready
);

    localparam logic [IDX_W-1:0] ADDR_START = IDX_W'(ttfd_pkg::ROT_OFFSET % SCAN_DEPTH);
    localparam logic [IDX_W-1:0] IDX_LAST   = IDX_W'(SCAN_DEPTH - 1);
    localparam logic [POS_W-1:0] POS_FULL   = POS_W'(SCAN_DEPTH);

    ttfd_pkg::state_t    state_reg, state_next;
    ttfd_pkg::scan_sel_t sel_reg, sel_next;
    ttfd_pkg::result_t   out_reg, out_next;
    logic                m_valid_reg, m_valid_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [IDX_W-1:0]    rd_addr_reg, rd_addr_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic                slot_free;
    logic                snap_req;
    logic                any_scan;
    logic                out_load;
    logic [7:0]          sample;

    assign slot_free = !m_valid_reg || m_ready;
    assign snap_req  = frame.button_bits[6];
    assign any_scan  = (frame.scan_a != '0) || (frame.scan_b != '0) || (frame.scan_c != '0);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ttfd_pkg::ST_IDLE: begin
                if (frame_sync) begin
                    state_next = ttfd_pkg::ST_FRAME;
                end
            end
            ttfd_pkg::ST_FRAME: begin
                if (slot_free) begin
                    if (snap_req) begin
                        state_next = ttfd_pkg::ST_SNAP;
                    end else if (any_scan) begin
                        state_next = ttfd_pkg::ST_WRITE;
                    end else begin
                        state_next = ttfd_pkg::ST_IDLE;
                    end
                end
            end
            ttfd_pkg::ST_SNAP: begin
                if (slot_free && (idx_reg == IDX_LAST)) begin
                    state_next = any_scan ? ttfd_pkg::ST_WRITE : ttfd_pkg::ST_IDLE;
                end
            end
            ttfd_pkg::ST_WRITE: begin
                if (sel_reg == ttfd_pkg::SEL_SCAN_C) begin
                    state_next = ttfd_pkg::ST_IDLE;
                end
            end
            default: state_next = ttfd_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        case (sel_reg)
            ttfd_pkg::SEL_SCAN_A: sample = frame.scan_a;
            ttfd_pkg::SEL_SCAN_B: sample = frame.scan_b;
            ttfd_pkg::SEL_SCAN_C: sample = frame.scan_c;
            default:              sample = frame.scan_c;
        endcase
    end

    always_comb begin
        s_ready      = 1'b0;
        out_load     = 1'b0;
        out_next     = out_reg;
        m_valid_next = m_valid_reg && !m_ready;
        rd_en        = 1'b0;
        wr_en        = 1'b0;
        wr_addr      = pos_reg[IDX_W-1:0];
        wr_data      = ~sample[ttfd_pkg::SAMPLE_W-1:0];
        idx_next     = idx_reg;
        rd_addr_next = rd_addr_reg;
        pos_next     = pos_reg;
        sel_next     = sel_reg;
        case (state_reg)
            ttfd_pkg::ST_IDLE: begin
                s_ready      = 1'b1;
                idx_next     = '0;
                rd_addr_next = ADDR_START;
                sel_next     = ttfd_pkg::SEL_SCAN_A;
            end
            ttfd_pkg::ST_FRAME: begin
                if (slot_free) begin
                    out_load             = 1'b1;
                    out_next             = '0;
                    out_next.result_kind = ttfd_pkg::RESULT_FRAME;
                    out_next.fields      = frame;
                    out_next.last        = !snap_req;
                    rd_en                = snap_req;
                    if (snap_req) begin
                        rd_addr_next = (rd_addr_reg == IDX_LAST) ? '0 : rd_addr_reg + IDX_W'(1);
                    end
                end
            end
            ttfd_pkg::ST_SNAP: begin
                if (slot_free) begin
                    out_load             = 1'b1;
                    out_next             = '0;
                    out_next.result_kind = ttfd_pkg::RESULT_SNAP;
                    out_next.snap_index  = ttfd_pkg::SNAP_IDX_W'(idx_reg);
                    out_next.snap_value  = rd_data;
                    out_next.last        = (idx_reg == IDX_LAST);
                    rd_en                = 1'b1;
                    rd_addr_next = (rd_addr_reg == IDX_LAST) ? '0 : rd_addr_reg + IDX_W'(1);
                    idx_next     = idx_reg + IDX_W'(1);
                    if (idx_reg == IDX_LAST) begin
                        pos_next = '0;
                        idx_next = '0;
                    end
                end
            end
            ttfd_pkg::ST_WRITE: begin
                if (pos_reg < POS_FULL) begin
                    wr_en    = 1'b1;
                    pos_next = pos_reg + POS_W'(1);
                end
                case (sel_reg)
                    ttfd_pkg::SEL_SCAN_A: sel_next = ttfd_pkg::SEL_SCAN_B;
                    ttfd_pkg::SEL_SCAN_B: sel_next = ttfd_pkg::SEL_SCAN_C;
                    default:              sel_next = ttfd_pkg::SEL_SCAN_A;
                endcase
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
        if (out_load) begin
            m_valid_next = 1'b1;
        end
    end

    assign rd_addr = rd_addr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ttfd_pkg::ST_IDLE;
            sel_reg     <= ttfd_pkg::SEL_SCAN_A;
            m_valid_reg <= 1'b0;
            idx_reg     <= '0;
            rd_addr_reg <= ADDR_START;
            pos_reg     <= '0;
        end else begin
            state_reg   <= state_next;
            sel_reg     <= sel_next;
            m_valid_reg <= m_valid_next;
            idx_reg     <= idx_next;
            rd_addr_reg <= rd_addr_next;
            pos_reg     <= pos_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    assign result  = out_reg;
    assign m_valid = m_valid_reg;

`ifndef SYNTHESIS
    a_write_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> (pos_reg < POS_FULL))
        else $error("store write past its end");

    a_load_needs_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> slot_free)
        else $error("result register overwritten before transfer");

    a_pos_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= POS_FULL)
        else $error("write position beyond store depth");

    a_snap_restarts_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ttfd_pkg::ST_SNAP && slot_free && idx_reg == IDX_LAST)
        |=> (pos_reg == '0))
        else $error("write position not restarted after readout");

    a_ready_only_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ttfd_pkg::ST_SNAP || state_reg == ttfd_pkg::ST_WRITE) |-> !s_ready)
        else $error("byte taken during readout or store update");
`endif

endmodule

### test/trainer_telemetry_frame_decoder_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for trainer_telemetry_frame_decoder: byte stream in, frame and
// spin-scan snapshot results out, compared against an in-bench frame decoder model.
// Depends on ttfd_pkg and the RTL of the block only.
module trainer_telemetry_frame_decoder_test;

    localparam int DEPTH = ttfd_pkg::SCAN_DEPTH_DEF;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_rx_byte = 8'h00;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_result_kind;
    logic [3:0]  m_msg_type;
    logic [7:0]  m_value_short;
    logic [11:0] m_value_long;
    logic [8:0]  m_button_bits;
    logic [7:0]  m_scan_a;
    logic [7:0]  m_scan_b;
    logic [7:0]  m_scan_c;
    logic [4:0]  m_snap_index;
    logic [6:0]  m_snap_value;
    logic        m_last;

    // model state
    logic [7:0] frame_buf [ttfd_pkg::FRAME_LEN];
    int         frame_cnt = 0;
    logic [6:0] scan_mem [DEPTH];
    int         scan_wr_pos = 0;

    ttfd_pkg::result_t pending_results [$];
    int      mismatch_count = 0;
    int      results_seen = 0;
    int      bytes_sent = 0;
    int      send_idle_pct = 0;
    int      recv_stall_pct = 0;

    trainer_telemetry_frame_decoder #(
        .SCAN_DEPTH(DEPTH)
    ) DUT (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_rx_byte(s_rx_byte),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_result_kind(m_result_kind),
        .m_msg_type(m_msg_type),
        .m_value_short(m_value_short),
        .m_value_long(m_value_long),
        .m_button_bits(m_button_bits),
        .m_scan_a(m_scan_a),
        .m_scan_b(m_scan_b),
        .m_scan_c(m_scan_c),
        .m_snap_index(m_snap_index),
        .m_snap_value(m_snap_value),
        .m_last(m_last)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #20_000_000;
        $display("trainer_telemetry_frame_decoder_test: FAIL");
        $finish;
    end

    initial begin
        foreach (frame_buf[i]) frame_buf[i] = 8'h00;
        foreach (scan_mem[i]) scan_mem[i] = 7'h00;
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic report_mismatch(input string what);
        $display("mismatch at result %0d: %s", results_seen, what);
        mismatch_count++;
    endtask

    task automatic compare_field(input string name, input logic [31:0] got,
                                 input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
    endtask

    function automatic logic [7:0] scan_byte(input logic [7:0] raw, input logic low_bit);
        logic [7:0] shifted;
        shifted = {raw[6:0], low_bit};
        return {shifted[3:0], shifted[7:4]};
    endfunction

    task automatic store_scan(input logic [7:0] sample);
        if (scan_wr_pos < DEPTH) begin
            scan_mem[scan_wr_pos] = ~sample[6:0];
            scan_wr_pos++;
        end
    endtask

    // Frame gatherer and decoder; pushes every result a transfer of b causes.
    task automatic decode_rx_byte(input logic [7:0] b);
        ttfd_pkg::result_t r;
        logic [7:0] sa;
        logic [7:0] sb;
        logic [7:0] sc;
        logic [7:0] v8;
        logic [8:0] btn;
        if (frame_cnt < ttfd_pkg::FRAME_LEN - 1) begin
            frame_buf[frame_cnt] = b;
            frame_cnt++;
            return;
        end
        frame_buf[ttfd_pkg::FRAME_LEN-1] = b;
        if (!b[7])
            return;
        frame_cnt = 0;

        sa = scan_byte(frame_buf[0], b[5]);
        sb = scan_byte(frame_buf[1], b[4]);
        sc = scan_byte(frame_buf[2], b[3]);
        btn = {frame_buf[3], b[2]};
        v8 = {frame_buf[5][6:0], b[0]};

        r = '0;
        r.result_kind = ttfd_pkg::RESULT_FRAME;
        r.fields.msg_type = frame_buf[4][6:3];
        r.fields.value_short = v8;
        r.fields.value_long = {frame_buf[4][2:0], b[1], v8};
        r.fields.button_bits = btn;
        r.fields.scan_a = sa;
        r.fields.scan_b = sb;
        r.fields.scan_c = sc;
        pending_results.push_back(r);

        if (btn[6]) begin
            for (int i = 0; i < DEPTH; i++) begin
                r = '0;
                r.result_kind = ttfd_pkg::RESULT_SNAP;
                r.snap_index = ttfd_pkg::SNAP_IDX_W'(i);
                r.snap_value = scan_mem[(i + ttfd_pkg::ROT_OFFSET) % DEPTH];
                pending_results.push_back(r);
            end
            scan_wr_pos = 0;
        end

        if (sa != 8'h00 || sb != 8'h00 || sc != 8'h00) begin
            store_scan(sa);
            store_scan(sb);
            store_scan(sc);
        end
        pending_results[pending_results.size()-1].last = 1'b1;
    endtask

    task automatic check_result();
        ttfd_pkg::result_t want;
        results_seen++;
        if (pending_results.size() == 0) begin
            report_mismatch("result transfer with nothing pending");
            return;
        end
        want = pending_results.pop_front();
        compare_field("result_kind", 32'(m_result_kind), 32'(want.result_kind));
        compare_field("msg_type", 32'(m_msg_type), 32'(want.fields.msg_type));
        compare_field("value_short", 32'(m_value_short), 32'(want.fields.value_short));
        compare_field("value_long", 32'(m_value_long), 32'(want.fields.value_long));
        compare_field("button_bits", 32'(m_button_bits), 32'(want.fields.button_bits));
        compare_field("scan_a", 32'(m_scan_a), 32'(want.fields.scan_a));
        compare_field("scan_b", 32'(m_scan_b), 32'(want.fields.scan_b));
        compare_field("scan_c", 32'(m_scan_c), 32'(want.fields.scan_c));
        compare_field("snap_index", 32'(m_snap_index), 32'(want.snap_index));
        compare_field("snap_value", 32'(m_snap_value), 32'(want.snap_value));
        compare_field("last", 32'(m_last), 32'(want.last));
    endtask

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                decode_rx_byte(s_rx_byte);
            if (m_valid && m_ready)
                check_result();
        end
    end

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_rx_byte <= b;
        do @(posedge aclk); while (!s_ready);
        bytes_sent++;
    endtask

    task automatic wait_results_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    task automatic send_random_frame();
        logic [7:0] fb [ttfd_pkg::FRAME_LEN];
        bit         zero_scan;
        bit         snap;
        int         junk;
        zero_scan = ($urandom_range(99) < 15);
        snap = ($urandom_range(99) < 12);
        junk = ($urandom_range(99) < 15) ? $urandom_range(1, 2) : 0;
        foreach (fb[i]) fb[i] = 8'($urandom);
        if (zero_scan) begin
            // bit 7 of a scan byte shifts out, so it may stay set
            for (int i = 0; i < 3; i++) fb[i] = fb[i] & 8'h80;
            fb[6][5:3] = 3'b000;
        end
        fb[3][5] = snap;
        fb[6][7] = 1'b1;
        for (int i = 0; i < ttfd_pkg::FRAME_LEN - 1; i++) send_byte(fb[i]);
        repeat (junk) send_byte({1'b0, 7'($urandom)});
        send_byte(fb[6]);
    endtask

    task automatic test_zero_frame();
        repeat (6) send_byte(8'h00);
        send_byte(8'h80);
    endtask

    // all ones: snapshot request plus three nonzero samples
    task automatic test_extreme_frame();
        repeat (7) send_byte(8'hFF);
    endtask

    task automatic test_unsynced_tail();
        send_byte(8'h12);
        send_byte(8'h34);
        send_byte(8'h56);
        send_byte(8'h20);
        send_byte(8'h5A);
        send_byte(8'h2B);
        send_byte(8'h7F);
        send_byte(8'h00);
        send_byte(8'hC5);
    endtask

    task automatic test_random_traffic(input int n_bytes);
        int start;
        start = bytes_sent;
        while (bytes_sent - start < n_bytes) begin
            if ($urandom_range(99) < 5)
                send_byte(8'($urandom));
            else
                send_random_frame();
        end
    endtask

    initial begin
        send_idle_pct = 12;
        recv_stall_pct = 74;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        test_zero_frame();
        test_extreme_frame();
        test_unsynced_tail();
        test_random_traffic(84);
        wait_results_drained();

        send_idle_pct = 74;
        recv_stall_pct = 12;
        test_random_traffic(83);
        wait_results_drained();

        send_idle_pct = 0;
        recv_stall_pct = 0;
        test_random_traffic(83);
        wait_results_drained();
        repeat (40) @(posedge aclk);

        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("trainer_telemetry_frame_decoder_test: PASS");
        else
            $display("trainer_telemetry_frame_decoder_test: FAIL");
        $finish;
    end

endmodule
